/* design/nca_pkg.sv */
`default_nettype none
package nca_pkg;

  localparam int MAX_CENTROIDS = 64;
  localparam int DIMENSIONS    = 4;
  localparam int COORD_W       = 32;
  localparam int SLOT_W        = 6;
  localparam int CNT_W         = 7;
  localparam int DIST_W        = 64;
  localparam int ACC_W         = 66;
  localparam int DIM_IDX_W     = 2;
  localparam int PH_W          = 3;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(DIMENSIONS + 1);

  typedef enum logic {
    CMD_LOAD     = 1'b0,
    CMD_CLASSIFY = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DIST,
    S_CMP,
    S_OUT
  } state_t;

  typedef logic [DIMENSIONS-1:0][COORD_W-1:0] coord_vec_t;

  typedef struct packed {
    logic            active;
    logic [PH_W-1:0] phase;
  } dist_ctrl_t;

endpackage
`default_nettype wire

/* design/nca_if.sv */
`default_nettype none
interface nca_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [5:0]  centroid_slot;
  logic [31:0] coord_a;
  logic [31:0] coord_b;
  logic [31:0] coord_c;
  logic [31:0] coord_d;

  modport source (output valid, cmd, centroid_slot, coord_a, coord_b, coord_c, coord_d,
                  input ready);
  modport sink (input valid, cmd, centroid_slot, coord_a, coord_b, coord_c, coord_d,
                output ready);
endinterface

interface nca_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  nearest_index;
  logic [63:0] nearest_distance_sq;

  modport source (output valid, nearest_index, nearest_distance_sq, input ready);
  modport sink (input valid, nearest_index, nearest_distance_sq, output ready);
endinterface
`default_nettype wire

/* design/nca_dist_unit.sv */
`default_nettype none
module nca_dist_unit (
  input  wire logic                               clk,
  input  wire nca_pkg::coord_vec_t                point,
  input  wire nca_pkg::coord_vec_t                row,
  input  wire nca_pkg::dist_ctrl_t                ctrl,
  output logic [nca_pkg::ACC_W-1:0]               dist_sq
);

  logic [nca_pkg::COORD_W-1:0]   pt_sel;
  logic [nca_pkg::COORD_W-1:0]   row_sel;
  logic [nca_pkg::COORD_W-1:0]   diff;
  logic [nca_pkg::COORD_W-1:0]   diff_r;
  logic [2*nca_pkg::COORD_W-1:0] prod_r;
  logic [nca_pkg::ACC_W-1:0]     acc_r;
  logic [nca_pkg::DIM_IDX_W-1:0] sel;

  assign sel     = ctrl.phase[nca_pkg::DIM_IDX_W-1:0];
  assign pt_sel  = point[sel];
  assign row_sel = row[sel];
  assign diff    = (pt_sel >= row_sel) ? (pt_sel - row_sel) : (row_sel - pt_sel);

  // three-stage walk: abs difference, square, accumulate
  always_ff @(posedge clk) begin
    if (ctrl.active) begin
      if (ctrl.phase < nca_pkg::PH_W'(nca_pkg::DIMENSIONS)) begin
        diff_r <= diff;
      end
      if (ctrl.phase >= nca_pkg::PH_W'(1) &&
          ctrl.phase <= nca_pkg::PH_W'(nca_pkg::DIMENSIONS)) begin
        prod_r <= diff_r * diff_r;
      end
      if (ctrl.phase == nca_pkg::PH_W'(2)) begin
        acc_r <= nca_pkg::ACC_W'(prod_r);
      end else if (ctrl.phase > nca_pkg::PH_W'(2)) begin
        acc_r <= acc_r + nca_pkg::ACC_W'(prod_r);
      end
    end
  end

  assign dist_sq = acc_r;

endmodule
`default_nettype wire

/* design/nearest_centroid_assign_unit.sv */
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    cmd, centroid_slot, coord_a..coord_d
//  out_ch    out  valid/ready    nearest_index, nearest_distance_sq
//  cfg       in   cfg_we         cfg_data (centroid_count)
//
//  a load writes the centroid store and gives no result
//  a classify walks the count centroids in turn after acceptance: per centroid a store read,
//  the shared subtract/multiply/accumulate walk, and a compare
//  in_ch.ready is high only in idle; a waiting result does not block the next transaction
//  a finished classify holds until the output register is free
//  rst_n is synchronous and active low; the centroid store is not cleared
`default_nettype none
module nearest_centroid_assign_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  nca_in_if.sink                          in_ch,
  nca_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [nca_pkg::CNT_W-1:0]  cfg_data
);

  nca_pkg::state_t               state_r, state_nxt;
  logic [nca_pkg::CNT_W-1:0]     centroid_count_r;
  logic [nca_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [nca_pkg::SLOT_W-1:0]    j_r, j_nxt;
  logic [nca_pkg::PH_W-1:0]      ph_r, ph_nxt;
  logic [nca_pkg::ACC_W-1:0]     best_r, best_nxt;
  logic [nca_pkg::SLOT_W-1:0]    best_idx_r, best_idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [nca_pkg::SLOT_W-1:0]    out_idx_r;
  logic [nca_pkg::DIST_W-1:0]    out_dist_r;
  nca_pkg::coord_vec_t           point_r;
  nca_pkg::coord_vec_t           row_r;
  nca_pkg::coord_vec_t           mem [nca_pkg::MAX_CENTROIDS];
  nca_pkg::dist_ctrl_t           dctrl;
  logic [nca_pkg::ACC_W-1:0]     dist_sq;
  logic                          in_fire, out_free, last_slot, take_result;
  logic [nca_pkg::CNT_W-1:0]     cnt_clamped;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign last_slot = ({1'b0, j_r} == (cnt_r - nca_pkg::CNT_W'(1)));

  always_comb begin
    cnt_clamped = centroid_count_r;
    if (centroid_count_r == '0) begin
      cnt_clamped = nca_pkg::CNT_W'(1);
    end else if (centroid_count_r > nca_pkg::CNT_W'(nca_pkg::MAX_CENTROIDS)) begin
      cnt_clamped = nca_pkg::CNT_W'(nca_pkg::MAX_CENTROIDS);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nca_pkg::S_IDLE: begin
        if (in_fire && nca_pkg::cmd_t'(in_ch.cmd) == nca_pkg::CMD_CLASSIFY) begin
          state_nxt = nca_pkg::S_FETCH;
        end
      end
      nca_pkg::S_FETCH: state_nxt = nca_pkg::S_DIST;
      nca_pkg::S_DIST: begin
        if (ph_r == nca_pkg::PH_LAST) begin
          state_nxt = nca_pkg::S_CMP;
        end
      end
      nca_pkg::S_CMP: state_nxt = last_slot ? nca_pkg::S_OUT : nca_pkg::S_FETCH;
      nca_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = nca_pkg::S_IDLE;
        end
      end
      default: state_nxt = nca_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cnt_nxt       = cnt_r;
    j_nxt         = j_r;
    ph_nxt        = ph_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    take_result   = 1'b0;
    dctrl.active  = 1'b0;
    dctrl.phase   = ph_r;
    case (state_r)
      nca_pkg::S_IDLE: begin
        cnt_nxt = cnt_clamped;
        j_nxt   = '0;
      end
      nca_pkg::S_FETCH: ph_nxt = '0;
      nca_pkg::S_DIST: begin
        dctrl.active = 1'b1;
        ph_nxt       = ph_r + nca_pkg::PH_W'(1);
      end
      nca_pkg::S_CMP: begin
        if (j_r == '0 || dist_sq < best_r) begin
          best_nxt     = dist_sq;
          best_idx_nxt = j_r;
        end
        j_nxt = j_r + nca_pkg::SLOT_W'(1);
      end
      nca_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          take_result   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= nca_pkg::S_IDLE;
      centroid_count_r <= nca_pkg::CNT_W'(1);
      out_valid_r      <= 1'b0;
      cnt_r            <= nca_pkg::CNT_W'(1);
      j_r              <= '0;
      ph_r             <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      j_r         <= j_nxt;
      ph_r        <= ph_nxt;
      if (cfg_we) begin
        centroid_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    if (in_fire) begin
      point_r <= {in_ch.coord_d, in_ch.coord_c, in_ch.coord_b, in_ch.coord_a};
    end
    if (take_result) begin
      out_idx_r  <= best_idx_r;
      out_dist_r <= (best_r[nca_pkg::ACC_W-1:nca_pkg::DIST_W] != '0) ?
                    '1 : best_r[nca_pkg::DIST_W-1:0];
    end
  end

  // centroid store
  always_ff @(posedge clk) begin
    if (in_fire && nca_pkg::cmd_t'(in_ch.cmd) == nca_pkg::CMD_LOAD) begin
      mem[in_ch.centroid_slot] <= {in_ch.coord_d, in_ch.coord_c, in_ch.coord_b,
                                   in_ch.coord_a};
    end
    if (state_r == nca_pkg::S_FETCH) begin
      row_r <= mem[j_r];
    end
  end

  nca_dist_unit u_dist (
    .clk     (clk),
    .point   (point_r),
    .row     (row_r),
    .ctrl    (dctrl),
    .dist_sq (dist_sq)
  );

  assign in_ch.ready                = (state_r == nca_pkg::S_IDLE);
  assign out_ch.valid               = out_valid_r;
  assign out_ch.nearest_index       = out_idx_r;
  assign out_ch.nearest_distance_sq = out_dist_r;

  a_dist_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nca_pkg::S_DIST && ph_r == nca_pkg::PH_LAST) |=> state_r == nca_pkg::S_CMP)
    else $error("distance walk did not end in compare");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nca_pkg::S_CMP) |-> ({1'b0, j_r} < cnt_r))
    else $error("compare on a slot beyond the count");

  a_count_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != nca_pkg::S_IDLE) |->
      (cnt_r >= nca_pkg::CNT_W'(1) && cnt_r <= nca_pkg::CNT_W'(nca_pkg::MAX_CENTROIDS)))
    else $error("centroid count out of range during classify");

  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nca_pkg::S_OUT && out_free) |=> (out_valid_r && state_r == nca_pkg::S_IDLE))
    else $error("finished classify not posted to the output register");

endmodule
`default_nettype wire
